FILE: rtl/core/large_tilemap_scroll_streamer_defines.svh
// Assertion shorthands for the scroll streamer; clocked on clk_i, off in reset.
`ifndef LARGE_TILEMAP_SCROLL_STREAMER_DEFINES_SVH
`define LARGE_TILEMAP_SCROLL_STREAMER_DEFINES_SVH

// same-cycle implication
`define LTSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ltss_pkg.sv
package ltss_pkg;

  localparam int unsigned RingColumns = 64;
  localparam int unsigned RingRows    = 32;
  localparam int unsigned MaxMapSide  = 1024;

  localparam int unsigned KindW  = 2;
  localparam int unsigned PosW   = 32;
  localparam int unsigned SvW    = 9;
  localparam int unsigned ColW   = $clog2(RingColumns);
  localparam int unsigned RowW   = $clog2(RingRows);
  localparam int unsigned SrcW   = 24;
  localparam int unsigned ModW   = $clog2(MaxMapSide);
  localparam int unsigned SideW  = ModW + 1;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned CfgIdxW = 1;
  // tile line coordinate: pos >>> 3 plus a small offset
  localparam int unsigned LineW  = PosW - 2;

  // bit positions inside the request kind
  localparam int unsigned KindAxisY = 0;
  localparam int unsigned KindWrap  = 1;

  localparam int unsigned MapWidthReset  = 64;
  localparam int unsigned MapHeightReset = 32;

  localparam int unsigned StepPix       = 8;
  localparam int unsigned ScreenMarginX = 256;
  localparam int unsigned ScreenMarginY = 192;
  localparam int unsigned FwdColOffset  = 34;
  localparam int unsigned FwdRowOffset  = 25;
  localparam int unsigned BackOffset    = 2;
  localparam int unsigned ColTilesClamp = 29;
  localparam int unsigned ColTilesWrap  = 28;
  localparam int unsigned RowTiles      = 37;
  localparam int unsigned CntW          = $clog2(RowTiles);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                    start;
    logic signed [LineW-1:0] value;
    logic [SideW-1:0]        modulus;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [ModW-1:0] result;
  } mod_rsp_t;

endpackage

FILE: rtl/core/ltss_intf.sv
interface ltss_req_if;
  import ltss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KindW-1:0]       kind;
  logic signed [PosW-1:0] target;

  modport source (output valid, kind, target, input ready);
  modport sink (input valid, kind, target, output ready);
endinterface

interface ltss_res_if;
  import ltss_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   result_kind;
  logic [SvW-1:0]         scroll_value;
  logic [ColW-1:0]        ring_column;
  logic [RowW-1:0]        ring_row;
  logic signed [SrcW-1:0] source_index;
  logic                   more_pending;
  logic                   last;

  modport source (output valid, result_kind, scroll_value, ring_column, ring_row,
                  source_index, more_pending, last, input ready);
  modport sink (input valid, result_kind, scroll_value, ring_column, ring_row,
                source_index, more_pending, last, output ready);
endinterface

FILE: rtl/core/ltss_mod.sv
// Non-negative modulo, restoring, one bit per cycle.
module ltss_mod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ltss_pkg::mod_req_t req_i,
  output ltss_pkg::mod_rsp_t rsp_o
);
  import ltss_pkg::*;

  localparam int unsigned BitCntW = $clog2(LineW);

  logic               busy_q;
  logic               done_q;
  logic               neg_q;
  logic [BitCntW-1:0] cnt_q;
  logic [LineW-1:0]   mag_q;
  logic [ModW-1:0]    rem_q;
  logic [SideW-1:0]   m_q;

  logic [SideW-1:0] trial;
  logic [SideW-1:0] trial_sub;
  logic [SideW-1:0] fix_w;
  logic             take;

  always_comb begin
    trial     = {rem_q, mag_q[LineW-1]};
    take      = (trial >= m_q);
    trial_sub = trial - m_q;
    fix_w     = m_q - {1'b0, rem_q};
  end

  // negative input: remainder of the magnitude folded back into 0..m-1
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (neg_q && (rem_q != '0)) ? fix_w[ModW-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= '0;
      rem_q  <= '0;
      m_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        neg_q  <= req_i.value[LineW-1];
        mag_q  <= req_i.value[LineW-1] ? LineW'(-req_i.value) : LineW'(req_i.value);
        rem_q  <= '0;
        m_q    <= req_i.modulus;
        cnt_q  <= BitCntW'(LineW - 1);
      end else if (busy_q) begin
        rem_q <= take ? trial_sub[ModW-1:0] : trial[ModW-1:0];
        mag_q <= {mag_q[LineW-2:0], 1'b0};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/large_tilemap_scroll_streamer.sv
// Channel | Dir | Payload                                              | Transfer
// req_i   | in  | kind, target                                         | valid && ready
// res_o   | out | result_kind, scroll_value, ring_column, ring_row,    | valid && ready
//         |     | source_index, more_pending, last                     |
// cfg     | in  | cfg_we_i, cfg_index_i, cfg_data_i                    | cfg_we_i high
//
// Flow: a request with no tile step goes through S_CLAMP, S_STEP, S_PEND and
// S_HEAD to its scroll result. A clamped step then adds its copy commands (29 or
// 37). A wrapping step first runs two passes of the one modulo unit, line then tile.
// Commands leave one per cycle through a single output register while res_o is ready.
// Reset: asynchronous, active low; scroll positions clear, map sides go to 64x32.
// Stalls: req_i.ready is high only between requests; a stalled output holds the
// sequencer, and the next request is taken while the final result still waits.
`include "large_tilemap_scroll_streamer_defines.svh"

module large_tilemap_scroll_streamer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ltss_req_if.sink                      req_i,
  ltss_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [ltss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ltss_pkg::CfgW-1:0]     cfg_data_i
);
  import ltss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_STEP,
    S_PEND,
    S_HEAD,
    S_MODF,
    S_MODV,
    S_EMIT
  } state_e;

  localparam logic signed [PosW:0] StepPos = (PosW+1)'(StepPix);
  localparam logic signed [PosW:0] StepNeg = -(PosW+1)'(StepPix);

  state_e state_q;

  // config
  logic [CfgW-1:0]  map_w_q;
  logic [CfgW-1:0]  map_h_q;
  logic [SideW-1:0] w_side;
  logic [SideW-1:0] h_side;

  // request context
  logic [KindW-1:0]       kind_q;
  logic signed [PosW-1:0] t_q;
  logic signed [PosW-1:0] pos_x_q;
  logic signed [PosW-1:0] pos_y_q;
  logic                   step_q;
  logic                   fwd_q;
  logic                   pend_q;
  logic signed [LineW-1:0] f_q;   // fixed line of the strip
  logic signed [LineW-1:0] v_q;   // running tile along the strip
  logic [ModW-1:0]        fm_q;
  logic [ModW-1:0]        vm_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        cnt_last_q;
  mod_req_t               mod_req_q;
  mod_rsp_t               mod_rsp;

  // output register
  logic                   out_valid_q;
  logic                   out_kind_q;
  logic [SvW-1:0]         out_sv_q;
  logic [ColW-1:0]        out_col_q;
  logic [RowW-1:0]        out_row_q;
  logic [SrcW-1:0]        out_src_q;
  logic                   out_pend_q;
  logic                   out_last_q;

  logic along_y;
  logic wrap;
  logic slot_free;
  logic in_xfer;

  logic signed [PosW-1:0]  lim_w;
  logic signed [PosW-1:0]  t_nn;
  logic signed [PosW-1:0]  t_cl;
  logic signed [PosW-1:0]  cur_w;
  logic signed [PosW:0]    diff_w;
  logic                    fwd_w;
  logic                    back_w;
  logic signed [PosW-4:0]  tx_w;
  logic signed [PosW-4:0]  ty_w;
  logic [SideW-1:0]        fmod_w;
  logic [SideW-1:0]        vmod_w;
  logic [SideW-1:0]        vm_wide_w;
  logic [SrcW-1:0]         a_w;
  logic [SrcW-1:0]         b_w;
  logic [SrcW-1:0]         prod_w;
  logic [SrcW-1:0]         src_w;
  logic [SvW-1:0]          sv_w;

  // out-of-range sides: 0 acts as 1, above the maximum saturates
  always_comb begin
    if (map_w_q == '0) begin
      w_side = SideW'(1);
    end else if (map_w_q > CfgW'(MaxMapSide)) begin
      w_side = SideW'(MaxMapSide);
    end else begin
      w_side = SideW'(map_w_q);
    end
    if (map_h_q == '0) begin
      h_side = SideW'(1);
    end else if (map_h_q > CfgW'(MaxMapSide)) begin
      h_side = SideW'(MaxMapSide);
    end else begin
      h_side = SideW'(map_h_q);
    end
  end

  assign along_y   = kind_q[KindAxisY];
  assign wrap      = kind_q[KindWrap];
  assign slot_free = !out_valid_q || res_o.ready;
  assign in_xfer   = req_i.valid && req_i.ready;

  always_comb begin
    // clamp: [0, side*8 - margin - 1]; small maps may end negative
    lim_w = along_y ? (PosW'({h_side, 3'b000}) - PosW'(ScreenMarginY))
                    : (PosW'({w_side, 3'b000}) - PosW'(ScreenMarginX));
    t_nn  = t_q[PosW-1] ? '0 : t_q;
    t_cl  = (t_nn >= lim_w) ? (lim_w - PosW'(1)) : t_nn;

    cur_w  = along_y ? pos_y_q : pos_x_q;
    diff_w = {t_q[PosW-1], t_q} - {cur_w[PosW-1], cur_w};
    fwd_w  = (diff_w >= StepPos);
    back_w = (diff_w <= StepNeg);

    // floor(pos / 8)
    tx_w = pos_x_q[PosW-1:3];
    ty_w = pos_y_q[PosW-1:3];

    fmod_w    = along_y ? h_side : w_side;
    vmod_w    = along_y ? w_side : h_side;
    vm_wide_w = {1'b0, vm_q};

    sv_w = along_y ? {1'b0, t_q[7:0]} : t_q[SvW-1:0];

    // x strip: column f, rows v; y strip: row f, columns v
    if (!along_y) begin
      a_w = wrap ? SrcW'(fm_q) : f_q[SrcW-1:0];
      b_w = wrap ? SrcW'(vm_q) : v_q[SrcW-1:0];
    end else begin
      a_w = wrap ? SrcW'(vm_q) : v_q[SrcW-1:0];
      b_w = wrap ? SrcW'(fm_q) : f_q[SrcW-1:0];
    end
    prod_w = b_w * SrcW'(w_side);
    src_w  = a_w + prod_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      map_w_q     <= CfgW'(MapWidthReset);
      map_h_q     <= CfgW'(MapHeightReset);
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      kind_q      <= '0;
      t_q         <= '0;
      step_q      <= 1'b0;
      fwd_q       <= 1'b0;
      pend_q      <= 1'b0;
      f_q         <= '0;
      v_q         <= '0;
      fm_q        <= '0;
      vm_q        <= '0;
      cnt_q       <= '0;
      cnt_last_q  <= '0;
      mod_req_q   <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_sv_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_src_q   <= '0;
      out_pend_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      mod_req_q.start <= 1'b0;

      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_MAP_WIDTH:  map_w_q <= cfg_data_i;
          REG_MAP_HEIGHT: map_h_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            kind_q  <= req_i.kind;
            t_q     <= req_i.target;
            state_q <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          if (!wrap) begin
            t_q <= t_cl;
          end
          state_q <= S_STEP;
        end

        // at most one tile step per request
        S_STEP: begin
          step_q <= fwd_w || back_w;
          fwd_q  <= fwd_w;
          if (fwd_w || back_w) begin
            if (along_y) begin
              pos_y_q <= fwd_w ? pos_y_q + PosW'(StepPix) : pos_y_q - PosW'(StepPix);
            end else begin
              pos_x_q <= fwd_w ? pos_x_q + PosW'(StepPix) : pos_x_q - PosW'(StepPix);
            end
          end
          state_q <= S_PEND;
        end

        // positions now hold the stepped value
        S_PEND: begin
          pend_q <= fwd_w || back_w;
          if (!along_y) begin
            f_q <= fwd_q ? LineW'(tx_w) + LineW'(FwdColOffset)
                         : LineW'(tx_w) - LineW'(BackOffset);
            v_q <= LineW'(ty_w) - LineW'(BackOffset);
            cnt_last_q <= wrap ? CntW'(ColTilesWrap - 1) : CntW'(ColTilesClamp - 1);
          end else begin
            f_q <= fwd_q ? LineW'(ty_w) + LineW'(FwdRowOffset)
                         : LineW'(ty_w) - LineW'(BackOffset);
            v_q <= LineW'(tx_w) - LineW'(BackOffset);
            cnt_last_q <= CntW'(RowTiles - 1);
          end
          cnt_q   <= '0;
          state_q <= S_HEAD;
        end

        S_HEAD: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= 1'b0;
            out_sv_q    <= sv_w;
            out_col_q   <= '0;
            out_row_q   <= '0;
            out_src_q   <= '0;
            out_pend_q  <= pend_q;
            out_last_q  <= !step_q;
            if (!step_q) begin
              state_q <= S_IDLE;
            end else if (wrap) begin
              mod_req_q.start   <= 1'b1;
              mod_req_q.value   <= f_q;
              mod_req_q.modulus <= fmod_w;
              state_q           <= S_MODF;
            end else begin
              state_q <= S_EMIT;
            end
          end
        end

        S_MODF: begin
          if (mod_rsp.done) begin
            fm_q              <= mod_rsp.result;
            mod_req_q.start   <= 1'b1;
            mod_req_q.value   <= v_q;
            mod_req_q.modulus <= vmod_w;
            state_q           <= S_MODV;
          end
        end

        S_MODV: begin
          if (mod_rsp.done) begin
            vm_q    <= mod_rsp.result;
            state_q <= S_EMIT;
          end
        end

        // one copy command per cycle while the output drains
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= 1'b1;
            out_sv_q    <= '0;
            out_col_q   <= along_y ? v_q[ColW-1:0] : f_q[ColW-1:0];
            out_row_q   <= along_y ? f_q[RowW-1:0] : v_q[RowW-1:0];
            out_src_q   <= src_w;
            out_pend_q  <= pend_q;
            out_last_q  <= (cnt_q == cnt_last_q);
            v_q         <= v_q + LineW'(1);
            vm_q        <= (vm_wide_w + SideW'(1) == vmod_w) ? '0 : vm_q + ModW'(1);
            cnt_q       <= cnt_q + CntW'(1);
            if (cnt_q == cnt_last_q) begin
              state_q <= S_IDLE;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  ltss_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req_q),
    .rsp_o  (mod_rsp)
  );

  assign req_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.result_kind  = out_kind_q;
  assign res_o.scroll_value = out_sv_q;
  assign res_o.ring_column  = out_col_q;
  assign res_o.ring_row     = out_row_q;
  assign res_o.source_index = out_src_q;
  assign res_o.more_pending = out_pend_q;
  assign res_o.last         = out_last_q;

  // modulo work only for a wrapping request that stepped
  `LTSS_ASSERT_IMP(a_mod_only_wrap, mod_req_q.start, wrap && step_q, "modulo started without a wrapping step")
  // running ring remainder stays below its side
  `LTSS_ASSERT_IMP(a_vm_range, (state_q == S_EMIT) && wrap, vm_wide_w < vmod_w, "running remainder out of range")
  // a new request cannot move the scroll position as it is accepted
  `LTSS_ASSERT_NXT(a_pos_hold, in_xfer, $stable(pos_x_q) && $stable(pos_y_q), "scroll position moved on accept")

endmodule

FILE: tb/tb_large_tilemap_scroll_streamer.sv
module tb_large_tilemap_scroll_streamer;
  timeunit 1ns;
  timeprecision 1ps;
  import ltss_pkg::*;

  // run shape
  localparam int PHASE_ITEMS    = 30;   // random requests per map-size setting
  localparam int NUM_PHASES     = 7;
  localparam int HOLD_PHASE     = 1;    // phase where the output is held off
  localparam int PAUSE_PHASE    = 4;    // phase with a mid-phase drain
  localparam int HOLD_BURST     = 14;   // back-to-back requests during the hold
  localparam int HOLD_CYCLES    = 400;
  localparam int CHASE_REACH    = 96;   // pixels around the current scroll position
  localparam int MAX_CHASE      = 16;   // repeats of one target before giving up
  localparam int SETTLE_CYCLES  = 12;
  localparam int TAIL_CYCLES    = 150;  // settle after the final drain
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  typedef enum logic [KindW-1:0] {
    KIND_CLAMP_X = 2'd0,
    KIND_CLAMP_Y = 2'd1,
    KIND_WRAP_X  = 2'd2,
    KIND_WRAP_Y  = 2'd3
  } req_kind_e;

  typedef enum logic {
    RES_SCROLL_VALUE = 1'b0,
    RES_TILE_COPY    = 1'b1
  } res_kind_e;

  typedef enum int {
    RX_STREAM,    // always ready
    RX_RANDOM,    // ready ~70% of cycles
    RX_PERIODIC,  // stalls at a regular period
    RX_STARVED    // ready ~25% of cycles
  } rx_mode_e;

  typedef struct packed {
    logic              res_kind;
    logic [SvW-1:0]    scroll;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [SrcW-1:0]   src;
    logic              more;
    logic              last;
  } tile_result_t;

  // Scroll/strip predictor plus the queue of results still owed by the block.
  class scroll_scoreboard;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [CfgW-1:0] width_reg;
    logic [CfgW-1:0] height_reg;
    bit              last_pending;
    tile_result_t    expected_q[$];
    int              failures;
    int              requests;
    int              checked;
    int              copies;
    int              steps;

    function new();
      pos_x        = '0;
      pos_y        = '0;
      width_reg    = CfgW'(MapWidthReset);
      height_reg   = CfgW'(MapHeightReset);
      last_pending = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int position(input logic [KindW-1:0] kind);
      return kind[KindAxisY] ? $signed(pos_y) : $signed(pos_x);
    endfunction

    // register 0 acts as 1, oversize acts as the max side
    function longint map_side(input logic [CfgW-1:0] reg_value);
      if (reg_value == '0) return 1;
      if (reg_value > MaxMapSide) return longint'(MaxMapSide);
      return longint'(reg_value);
    endfunction

    function longint floor_mod(input longint v, input longint m);
      longint r;
      r = v % m;
      return (r < 0) ? r + m : r;
    endfunction

    function void push_result(input res_kind_e kind, input longint scroll, input longint col,
                              input longint row, input longint src, input bit more,
                              input bit last);
      tile_result_t r;
      r.res_kind = kind;
      r.scroll   = SvW'(scroll);
      r.col      = ColW'(col);
      r.row      = RowW'(row);
      r.src      = SrcW'(src);
      r.more     = more;
      r.last     = last;
      expected_q.push_back(r);
    endfunction

    function void note_request(input logic [KindW-1:0] kind,
                               input logic signed [PosW-1:0] target);
      bit     along_y, wrapping, more;
      longint w, h, t, lim, cur, tx, ty, line, span_pos;
      int     dir, cnt, i;
      along_y  = kind[KindAxisY];
      wrapping = kind[KindWrap];
      w = map_side(width_reg);
      h = map_side(height_reg);
      t = target;
      // clamped: keep the screen inside the map (may go negative on tiny maps)
      if (!wrapping) begin
        lim = along_y ? h * 8 - longint'(ScreenMarginY) : w * 8 - longint'(ScreenMarginX);
        if (t < 0) t = 0;
        if (t >= lim) t = lim - 1;
      end
      cur = along_y ? longint'($signed(pos_y)) : longint'($signed(pos_x));
      dir = 0;
      if (t - cur >= longint'(StepPix)) dir = 1;
      else if (t - cur <= -longint'(StepPix)) dir = -1;
      cur = cur + dir * longint'(StepPix);
      if (along_y) pos_y = PosW'(cur);
      else pos_x = PosW'(cur);
      more = (t - cur >= longint'(StepPix)) || (t - cur <= -longint'(StepPix));
      last_pending = more;
      requests++;
      push_result(RES_SCROLL_VALUE, t & (along_y ? 255 : 511), 0, 0, 0, more, dir == 0);
      if (dir == 0) return;
      steps++;
      tx = longint'($signed(pos_x)) >>> $clog2(StepPix);
      ty = longint'($signed(pos_y)) >>> $clog2(StepPix);
      if (!along_y) begin
        // newly exposed column
        line = (dir > 0) ? tx + longint'(FwdColOffset) : tx - longint'(BackOffset);
        cnt  = wrapping ? ColTilesWrap : ColTilesClamp;
        for (i = 0; i < cnt; i++) begin
          span_pos = ty - longint'(BackOffset) + i;
          push_result(RES_TILE_COPY, 0, line, span_pos,
                      wrapping ? floor_mod(line, w) + floor_mod(span_pos, h) * w
                               : line + span_pos * w,
                      more, i == cnt - 1);
        end
      end else begin
        // newly exposed row
        line = (dir > 0) ? ty + longint'(FwdRowOffset) : ty - longint'(BackOffset);
        cnt  = RowTiles;
        for (i = 0; i < cnt; i++) begin
          span_pos = tx - longint'(BackOffset) + i;
          push_result(RES_TILE_COPY, 0, span_pos, line,
                      wrapping ? floor_mod(span_pos, w) + floor_mod(line, h) * w
                               : span_pos + line * w,
                      more, i == cnt - 1);
        end
      end
      copies += cnt;
    endfunction

    function void check_result(input tile_result_t got);
      tile_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d arrived with nothing outstanding: kind %0d scroll %0d col %0d row %0d src %0d more %0b last %0b",
                   checked, got.res_kind, got.scroll, got.col, got.row, $signed(got.src),
                   got.more, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got.res_kind !== want.res_kind || got.scroll !== want.scroll ||
          got.col !== want.col || got.row !== want.row || got.src !== want.src ||
          got.more !== want.more || got.last !== want.last) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("result %0d mismatch: expected kind %0d scroll %0d col %0d row %0d src %0d more %0b last %0b",
                   checked, want.res_kind, want.scroll, want.col, want.row, $signed(want.src),
                   want.more, want.last);
          $display("                          got kind %0d scroll %0d col %0d row %0d src %0d more %0b last %0b",
                   got.res_kind, got.scroll, got.col, got.row, $signed(got.src),
                   got.more, got.last);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we;
  cfg_reg_e          cfg_index;
  logic [CfgW-1:0]   cfg_data;

  ltss_req_if req_if();
  ltss_res_if res_if();

  scroll_scoreboard sb = new();

  // sender / receiver coordination
  int sent_count  = 0;
  int burst_left  = 0;
  bit no_gaps     = 1'b0;
  bit hold_asked  = 1'b0;  // written by stimulus only
  bit hold_served = 1'b0;  // written by the receiver only

  large_tilemap_scroll_streamer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the transfer. Back-to-back requests
  // keep valid high; at the end of a burst valid drops for a random gap.
  task automatic send_item(input req_kind_e k, input logic signed [PosW-1:0] t);
    int gap;
    req_if.valid  <= 1'b1;
    req_if.kind   <= k;
    req_if.target <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(k, t);
    sent_count++;
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Directed request; target either absolute or relative to the kept position.
  task automatic probe(input req_kind_e k, input bit relative, input int value);
    send_item(k, relative ? sb.position(k) + value : value);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained(input int settle);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_sides(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAP_WIDTH;
    cfg_data  <= w;
    @(posedge clk_i);
    cfg_index <= REG_MAP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.width_reg  = w;
    sb.height_reg = h;
    @(posedge clk_i);
  endtask

  // Result monitor: every transfer on the output goes to the scoreboard.
  always @(posedge clk_i) begin : result_monitor
    tile_result_t seen;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.res_kind = res_if.result_kind;
      seen.scroll   = res_if.scroll_value;
      seen.col      = res_if.ring_column;
      seen.row      = res_if.ring_row;
      seen.src      = res_if.source_index;
      seen.more     = res_if.more_pending;
      seen.last     = res_if.last;
      sb.check_result(seen);
    end
  end

  // Receiver: stall pattern changes every span; one long hold-off on request.
  initial begin : receiver
    rx_mode_e mode;
    int       span, tick;
    res_if.ready = 1'b0;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = rx_mode_e'($urandom_range(RX_STREAM, RX_STARVED));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk_i);
        if (hold_asked && !hold_served) begin
          // block backs up and must stall its input
          res_if.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_served = 1'b1;
        end
        tick++;
        case (mode)
          RX_STREAM:   res_if.ready <= 1'b1;
          RX_RANDOM:   res_if.ready <= ($urandom_range(0, 9) < 7);
          RX_PERIODIC: res_if.ready <= (tick % 4 != 0);
          default:     res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
             WATCHDOG_LIMIT, sb.pending());
    $display("tb_large_tilemap_scroll_streamer: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CfgW-1:0]        w_side, h_side;
    logic signed [PosW-1:0] goal;
    req_kind_e              k;
    int                     phase, phase_start, chase, offset;
    bit                     paused;
    req_if.valid  = 1'b0;
    req_if.kind   = '0;
    req_if.target = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_MAP_WIDTH;
    cfg_data      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, 64x32 map from reset.
    probe(KIND_CLAMP_X, 1'b0, 32'sh8000_0000);  // negative clamps to 0, no step
    probe(KIND_CLAMP_X, 1'b0, 32'sh7FFF_FFFF);  // clamps to right edge, steps
    probe(KIND_CLAMP_X, 1'b1, 7);               // just under a tile: no step
    probe(KIND_CLAMP_X, 1'b1, 8);               // exactly a tile: step
    probe(KIND_CLAMP_Y, 1'b0, 32'sh7FFF_FFFF);  // clamps to bottom edge
    probe(KIND_CLAMP_Y, 1'b0, -5);              // back to top
    probe(KIND_WRAP_X, 1'b1, -8);               // backward column
    probe(KIND_WRAP_X, 1'b1, -7);
    repeat (4) probe(KIND_WRAP_X, 1'b0, 32'sh8000_0000);  // into negative x
    repeat (3) probe(KIND_WRAP_Y, 1'b0, 32'sh8000_0000);  // into negative y
    probe(KIND_WRAP_Y, 1'b0, 32'sh7FFF_FFFF);
    probe(KIND_WRAP_Y, 1'b1, 8);
    probe(KIND_CLAMP_Y, 1'b1, -8);              // clamped on negative y: steps forward
    probe(KIND_WRAP_X, 1'b1, 300);              // sets the top scroll bit
    probe(KIND_CLAMP_X, 1'b0, 256);             // first value past the edge
    probe(KIND_CLAMP_X, 1'b0, 255);

    // Random part over several map sizes; sizes only change with the block idle.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained(SETTLE_CYCLES);
      case (phase)
        0:       begin w_side = 1;    h_side = 1;    end  // smaller than the screen
        1:       begin w_side = 1024; h_side = 1024; end
        2:       begin w_side = 0;    h_side = 2047; end  // out-of-range sides
        3:       begin w_side = 2047; h_side = 0;    end
        4:       begin
          w_side = $urandom_range(1, 48);
          h_side = $urandom_range(1, 48);
        end
        5:       begin w_side = 37;   h_side = 700;  end
        default: begin w_side = 64;   h_side = 32;   end
      endcase
      write_sides(w_side, h_side);
      phase_start = sent_count;
      paused      = 1'b0;
      if (phase == HOLD_PHASE) begin
        hold_asked = 1'b1;
        no_gaps    = 1'b1;
      end else begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      while (sent_count - phase_start < PHASE_ITEMS) begin
        if (phase == HOLD_PHASE && sent_count - phase_start >= HOLD_BURST) no_gaps = 1'b0;
        if (phase == PAUSE_PHASE && !paused && sent_count - phase_start >= PHASE_ITEMS / 2)
        begin
          wait_drained(0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 75) begin
          // chase a nearby target until it is reached, with the odd stray request
          k      = req_kind_e'($urandom_range(KIND_CLAMP_X, KIND_WRAP_Y));
          offset = int'($urandom_range(0, 2 * CHASE_REACH)) - CHASE_REACH;
          goal   = sb.position(k) + offset;
          chase  = 0;
          do begin
            if ($urandom_range(0, 9) == 0)
              send_item(req_kind_e'($urandom_range(KIND_CLAMP_X, KIND_WRAP_Y)), $urandom);
            send_item(k, goal);
            chase++;
          end while (sb.last_pending && chase < MAX_CHASE);
        end else begin
          goal = ($urandom_range(0, 1) == 1) ? $urandom : int'($urandom_range(0, 4095)) - 2048;
          send_item(req_kind_e'($urandom_range(KIND_CLAMP_X, KIND_WRAP_Y)), goal);
        end
      end
    end

    wait_drained(TAIL_CYCLES);
    $display("covered %0d requests (%0d tile steps) and %0d results with %0d tile copies",
             sb.requests, sb.steps, sb.checked, sb.copies);
    $display("over %0d map-size settings, one %0d-cycle output hold-off, %0d mismatches",
             NUM_PHASES + 1, HOLD_CYCLES, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_large_tilemap_scroll_streamer: PASS");
    end else begin
      $display("tb_large_tilemap_scroll_streamer: FAIL");
    end
    $finish;
  end

endmodule
